>>> rtl/tpt_pkg.sv
// ----------------------------------------------------------------------------
// tpt_pkg
// Shared sizes, command codes, state encoding and memory word layouts for the
// timed Petri net transition firing block.
// ----------------------------------------------------------------------------
`default_nettype none

package tpt_pkg;

  // Net dimensions
  localparam int MAX_PLACES      = 64;
  localparam int MAX_TRANSITIONS = 64;

  // Derived sizes
  localparam int ARC_DEPTH = MAX_PLACES * MAX_TRANSITIONS;
  localparam int ARC_AW    = $clog2(ARC_DEPTH);
  localparam int PLACE_AW  = $clog2(MAX_PLACES);
  localparam int CNT_W     = $clog2(MAX_PLACES + 1);

  // Command codes
  localparam logic [1:0] CMD_ARC   = 2'd0;
  localparam logic [1:0] CMD_PLACE = 2'd1;
  localparam logic [1:0] CMD_FIRE  = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_COST,
    ST_EMIT
  } state_t;

  // One incidence entry: token change and input arc weight
  typedef struct packed {
    logic [7:0] change;
    logic [7:0] pre;
  } arc_entry_t;

  // One place entry: delay, source tokens, time waited
  typedef struct packed {
    logic [15:0] delay;
    logic [15:0] tokens;
    logic [23:0] waited;
  } place_entry_t;

  // Row-major incidence address: transition * MAX_PLACES + place
  function automatic logic [ARC_AW-1:0] arc_addr(input logic [5:0]          t,
                                                 input logic [PLACE_AW-1:0] p);
    return ARC_AW'(t) * ARC_AW'(MAX_PLACES) + ARC_AW'(p);
  endfunction

endpackage

`default_nettype wire

>>> rtl/timed_petri_transition_fire.sv
// ----------------------------------------------------------------------------
// timed_petri_transition_fire
// Fires one transition of a place-timed Petri net held in on-chip memories.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (item_valid / item_stall) carries one command word per
//   transfer. An arc write or a place write gives no result. A fire word
//   walks the active places twice out of the two memories: a first pass
//   finds the firing delay (one place per cycle, through a read, multiply
//   and compare pipeline), a second pass emits one result word per active
//   place, place 0 first, with last set on the final one. A firing's length
//   is bounded by the single read port of each memory; item_stall is high
//   for that whole time.
//   Result channel (result_valid / result_stall) is a registered output
//   stage. While the receiver stalls, the emit pass holds its read pipeline
//   and the word on the port does not change; a new input word may be taken
//   while the final result still waits.
//   After rst, a clearing pass zeroes both memories, one incidence entry a
//   cycle over all 4096 entries; item_stall stays high during it. The place
//   count register (cfg_write_en / cfg_write_data) resets to 64 and may be
//   written at any time the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_petri_transition_fire (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_write_en,
  input  wire logic [6:0]  cfg_write_data,
  // input words
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [5:0]  place_index,
  input  wire logic [5:0]  transition_index,
  input  wire logic [7:0]  token_change,
  input  wire logic [7:0]  pre_weight,
  input  wire logic [15:0] place_delay,
  input  wire logic [15:0] source_tokens,
  input  wire logic [23:0] source_waited,
  input  wire logic [31:0] cost_so_far,
  // result words
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [5:0]       out_place,
  output logic [15:0]      new_tokens,
  output logic [23:0]      new_waited,
  output logic [23:0]      firing_delay,
  output logic [31:0]      new_cost,
  output logic [6:0]       transition_number,
  output logic             went_negative,
  output logic             last
);

  // --------------------------------------------------------------------------
  // Declarations
  // --------------------------------------------------------------------------
  tpt_pkg::state_t state, state_next;

  logic [tpt_pkg::ARC_AW-1:0]   clr_cnt;
  logic [6:0]                   place_count;
  logic [tpt_pkg::CNT_W-1:0]    active;
  logic [tpt_pkg::CNT_W-1:0]    active_in;
  logic [tpt_pkg::CNT_W-1:0]    iss;
  logic [tpt_pkg::PLACE_AW-1:0] rd_idx;
  logic [5:0]                   trans;
  logic [31:0]                  cost_in;
  logic [31:0]                  cost;
  logic [23:0]                  step;
  logic [23:0]                  need;
  logic [23:0]                  need_wait;
  logic [23:0]                  diff;
  logic                         rd_valid;
  logic                         mul_valid;

  logic accept, t_ok, p_ok, fire_go, clr_done;
  logic rd_en, out_load, arc_we, place_we;

  logic [tpt_pkg::ARC_AW-1:0]   arc_waddr, arc_raddr;
  logic [tpt_pkg::PLACE_AW-1:0] place_waddr, place_raddr;
  tpt_pkg::arc_entry_t          arc_wdata, arc_rdata;
  tpt_pkg::place_entry_t        place_wdata, place_rdata;

  tpt_pkg::arc_entry_t   arc_mem   [tpt_pkg::ARC_DEPTH];
  tpt_pkg::place_entry_t place_mem [tpt_pkg::MAX_PLACES];

  logic [17:0] tok_sum;
  logic        tok_neg, tok_over;
  logic [15:0] tok_new;
  logic [24:0] wait_sum;
  logic [23:0] wait_new;
  logic [32:0] cost_sum;

  // --------------------------------------------------------------------------
  // Input decode
  // --------------------------------------------------------------------------
  assign accept   = item_valid && !item_stall;
  assign t_ok     = int'(transition_index) < tpt_pkg::MAX_TRANSITIONS;
  assign p_ok     = int'(place_index) < tpt_pkg::MAX_PLACES;
  assign clr_done = clr_cnt == tpt_pkg::ARC_AW'(tpt_pkg::ARC_DEPTH - 1);

  // Clip the place count to the table size
  always_comb begin
    if (int'(place_count) > tpt_pkg::MAX_PLACES) begin
      active_in = tpt_pkg::CNT_W'(tpt_pkg::MAX_PLACES);
    end else begin
      active_in = tpt_pkg::CNT_W'(place_count);
    end
  end

  assign fire_go = accept && (cmd == tpt_pkg::CMD_FIRE) && t_ok && (active_in != '0);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      tpt_pkg::ST_CLEAR: begin
        if (clr_done) state_next = tpt_pkg::ST_IDLE;
      end
      tpt_pkg::ST_IDLE: begin
        if (fire_go) state_next = tpt_pkg::ST_SCAN;
      end
      tpt_pkg::ST_SCAN: begin
        if (iss == active && !rd_valid && !mul_valid) state_next = tpt_pkg::ST_COST;
      end
      tpt_pkg::ST_COST: begin
        state_next = tpt_pkg::ST_EMIT;
      end
      tpt_pkg::ST_EMIT: begin
        if (iss == active && !rd_valid) state_next = tpt_pkg::ST_IDLE;
      end
      default: begin
        state_next = tpt_pkg::ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control outputs
  // --------------------------------------------------------------------------
  always_comb begin
    item_stall = 1'b1;
    rd_en      = 1'b0;
    out_load   = 1'b0;
    arc_we     = 1'b0;
    place_we   = 1'b0;
    case (state)
      tpt_pkg::ST_CLEAR: begin
        arc_we   = 1'b1;
        place_we = int'(clr_cnt) < tpt_pkg::MAX_PLACES;
      end
      tpt_pkg::ST_IDLE: begin
        item_stall = 1'b0;
        arc_we     = accept && (cmd == tpt_pkg::CMD_ARC) && t_ok && p_ok;
        place_we   = accept && (cmd == tpt_pkg::CMD_PLACE) && p_ok;
      end
      tpt_pkg::ST_SCAN: begin
        rd_en = iss < active;
      end
      tpt_pkg::ST_COST: begin
        rd_en = 1'b0;
      end
      tpt_pkg::ST_EMIT: begin
        out_load = rd_valid && (!result_valid || !result_stall);
        rd_en    = (iss < active) && (!rd_valid || out_load);
      end
      default: begin
        item_stall = 1'b1;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Memory ports: writes happen only while idle or clearing, reads only
  // while firing, so the same entry is never read and written together.
  // --------------------------------------------------------------------------
  always_comb begin
    if (state == tpt_pkg::ST_CLEAR) begin
      arc_waddr   = clr_cnt;
      place_waddr = clr_cnt[tpt_pkg::PLACE_AW-1:0];
      arc_wdata   = '0;
      place_wdata = '0;
    end else begin
      arc_waddr   = tpt_pkg::arc_addr(transition_index,
                                      place_index[tpt_pkg::PLACE_AW-1:0]);
      place_waddr = place_index[tpt_pkg::PLACE_AW-1:0];
      arc_wdata   = '{change: token_change, pre: pre_weight};
      place_wdata = '{delay: place_delay, tokens: source_tokens, waited: source_waited};
    end
  end

  assign place_raddr = iss[tpt_pkg::PLACE_AW-1:0];
  assign arc_raddr   = tpt_pkg::arc_addr(trans, place_raddr);

  // Incidence memory
  always_ff @(posedge clk) begin
    if (arc_we) arc_mem[arc_waddr] <= arc_wdata;
    if (rd_en) arc_rdata <= arc_mem[arc_raddr];
  end

  // Place memory
  always_ff @(posedge clk) begin
    if (place_we) place_mem[place_waddr] <= place_wdata;
    if (rd_en) place_rdata <= place_mem[place_raddr];
  end

  // --------------------------------------------------------------------------
  // Per-place result math
  // --------------------------------------------------------------------------
  assign diff     = need - need_wait;
  assign tok_sum  = {2'b00, place_rdata.tokens} +
                    {{10{arc_rdata.change[7]}}, arc_rdata.change};
  assign tok_neg  = tok_sum[17];
  assign tok_over = !tok_sum[17] && tok_sum[16];
  assign wait_sum = {1'b0, place_rdata.waited} + {1'b0, step};
  assign cost_sum = {1'b0, cost_in} + 33'(step);

  // Clamp the marking
  always_comb begin
    if (tok_neg) begin
      tok_new = '0;
    end else if (tok_over) begin
      tok_new = '1;
    end else begin
      tok_new = tok_sum[15:0];
    end
  end

  // Drop the wait on an untimed, emptied or formerly empty place
  always_comb begin
    if (place_rdata.delay == '0 || tok_new == '0 || place_rdata.tokens == '0) begin
      wait_new = '0;
    end else if (wait_sum[24]) begin
      wait_new = '1;
    end else begin
      wait_new = wait_sum[23:0];
    end
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= tpt_pkg::ST_CLEAR;
      clr_cnt      <= '0;
      place_count  <= 7'd64;
      active       <= '0;
      iss          <= '0;
      rd_valid     <= 1'b0;
      mul_valid    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;

      // advance the clearing sweep
      if (state == tpt_pkg::ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;

      if (cfg_write_en) place_count <= cfg_write_data;

      if (fire_go) begin
        active <= active_in;
        iss    <= '0;
      end else if (state == tpt_pkg::ST_COST) begin
        iss <= '0;
      end else if (rd_en) begin
        iss <= iss + 1'b1;
      end

      // read pipeline valid bits
      case (state)
        tpt_pkg::ST_SCAN: begin
          rd_valid  <= rd_en;
          mul_valid <= rd_valid;
        end
        tpt_pkg::ST_EMIT: begin
          mul_valid <= 1'b0;
          if (rd_en) begin
            rd_valid <= 1'b1;
          end else if (out_load) begin
            rd_valid <= 1'b0;
          end
        end
        default: begin
          rd_valid  <= 1'b0;
          mul_valid <= 1'b0;
        end
      endcase

      // output word handshake
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    // latch the fire word
    if (fire_go) begin
      trans   <= transition_index;
      cost_in <= cost_so_far;
      step    <= '0;
    end else if (state == tpt_pkg::ST_SCAN && mul_valid && need > need_wait
                 && diff > step) begin
      step <= diff;
    end

    if (rd_en) rd_idx <= place_raddr;

    // weighted holding time of this place
    if (state == tpt_pkg::ST_SCAN && rd_valid) begin
      need      <= 24'(place_rdata.delay) * 24'(arc_rdata.pre);
      need_wait <= place_rdata.waited;
    end

    // saturate the new cost
    if (state == tpt_pkg::ST_COST) begin
      cost <= cost_sum[32] ? '1 : cost_sum[31:0];
    end

    // fill the output word
    if (out_load) begin
      out_place         <= 6'(rd_idx);
      new_tokens        <= tok_new;
      new_waited        <= wait_new;
      firing_delay      <= step;
      new_cost          <= cost;
      transition_number <= 7'(trans) + 7'd1;
      went_negative     <= tok_neg || tok_over;
      last              <= tpt_pkg::CNT_W'(rd_idx) + 1'b1 == active;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_result_while_clearing: assert property (
    @(posedge clk) disable iff (rst)
    state == tpt_pkg::ST_CLEAR |-> !result_valid
  ) else $error("result word during clearing pass");

  a_issue_in_range: assert property (
    @(posedge clk) disable iff (rst)
    (state == tpt_pkg::ST_SCAN || state == tpt_pkg::ST_EMIT) |-> iss <= active
  ) else $error("read issue past the active place count");

  a_read_only_when_firing: assert property (
    @(posedge clk) disable iff (rst)
    rd_valid |-> (state == tpt_pkg::ST_SCAN || state == tpt_pkg::ST_EMIT)
  ) else $error("read data pending outside a firing");

  a_emit_index_in_range: assert property (
    @(posedge clk) disable iff (rst)
    (state == tpt_pkg::ST_EMIT && rd_valid) |-> tpt_pkg::CNT_W'(rd_idx) < active
  ) else $error("emitted place beyond active count");

  a_cost_then_emit: assert property (
    @(posedge clk) disable iff (rst)
    state == tpt_pkg::ST_COST |=> state == tpt_pkg::ST_EMIT && iss == '0
  ) else $error("emit pass did not start after cost update");

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for timed_petri_transition_fire. A behavioral copy of
// the net tables predicts every result word of each firing; a checker
// compares the result words in order, field by field, while both channels
// idle and stall at random.
// ----------------------------------------------------------------------------

module tb;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RESET_CYCLES    = 8;
  localparam int SETTLE_CYCLES   = 200;
  localparam int WATCHDOG_CYCLES = 20000;
  localparam int MAX_REPORTS     = 10;

  // One input word as the sender drives it
  typedef struct packed {
    logic [1:0]  cmd;
    logic [5:0]  place_index;
    logic [5:0]  transition_index;
    logic [7:0]  token_change;
    logic [7:0]  pre_weight;
    logic [15:0] place_delay;
    logic [15:0] source_tokens;
    logic [23:0] source_waited;
    logic [31:0] cost_so_far;
  } net_word_t;

  // One expected result word
  typedef struct packed {
    logic [5:0]  place;
    logic [15:0] tokens;
    logic [23:0] waited;
    logic [23:0] delay;
    logic [31:0] cost;
    logic [6:0]  tnum;
    logic        neg;
    logic        last;
  } place_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic [6:0]  cfg_write_data = 7'd0;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [1:0]  cmd = 2'd0;
  logic [5:0]  place_index = 6'd0;
  logic [5:0]  transition_index = 6'd0;
  logic [7:0]  token_change = 8'd0;
  logic [7:0]  pre_weight = 8'd0;
  logic [15:0] place_delay = 16'd0;
  logic [15:0] source_tokens = 16'd0;
  logic [23:0] source_waited = 24'd0;
  logic [31:0] cost_so_far = 32'd0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [5:0]  out_place;
  logic [15:0] new_tokens;
  logic [23:0] new_waited;
  logic [23:0] firing_delay;
  logic [31:0] new_cost;
  logic [6:0]  transition_number;
  logic        went_negative;
  logic        last;

  // Predicted net state
  logic signed [7:0] incidence  [tpt_pkg::MAX_PLACES*tpt_pkg::MAX_TRANSITIONS];
  logic [7:0]        arc_weight [tpt_pkg::MAX_PLACES*tpt_pkg::MAX_TRANSITIONS];
  logic [15:0]       hold_time  [tpt_pkg::MAX_PLACES];
  logic [15:0]       src_tokens [tpt_pkg::MAX_PLACES];
  logic [23:0]       src_waited [tpt_pkg::MAX_PLACES];
  logic [6:0]        active_places = 7'd64;

  place_result_t expected_places[$];
  int  mismatch_count = 0;
  int  words_sent = 0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;

  timed_petri_transition_fire uut (
    .clk               (clk),
    .rst               (rst),
    .cfg_write_en      (cfg_write_en),
    .cfg_write_data    (cfg_write_data),
    .item_valid        (item_valid),
    .item_stall        (item_stall),
    .cmd               (cmd),
    .place_index       (place_index),
    .transition_index  (transition_index),
    .token_change      (token_change),
    .pre_weight        (pre_weight),
    .place_delay       (place_delay),
    .source_tokens     (source_tokens),
    .source_waited     (source_waited),
    .cost_so_far       (cost_so_far),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .out_place         (out_place),
    .new_tokens        (new_tokens),
    .new_waited        (new_waited),
    .firing_delay      (firing_delay),
    .new_cost          (new_cost),
    .transition_number (transition_number),
    .went_negative     (went_negative),
    .last              (last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Clear the predicted tables to match the state after reset
  initial begin
    for (int i = 0; i < tpt_pkg::MAX_PLACES*tpt_pkg::MAX_TRANSITIONS; i++) begin
      incidence[i]  = 8'sd0;
      arc_weight[i] = 8'd0;
    end
    for (int i = 0; i < tpt_pkg::MAX_PLACES; i++) begin
      hold_time[i]  = 16'd0;
      src_tokens[i] = 16'd0;
      src_waited[i] = 24'd0;
    end
  end

  // Zero, all ones, or a random value of the given width
  function automatic logic [31:0] pick_value(input int bits);
    longint unsigned mask;
    mask = (64'd1 << bits) - 1;
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'(mask);
      default: return 32'($urandom & mask);
    endcase
  endfunction

  function automatic net_word_t random_word();
    net_word_t w;
    w.cmd              = 2'($urandom_range(0, 3));
    w.place_index      = 6'($urandom);
    w.transition_index = 6'($urandom);
    w.token_change     = 8'(pick_value(8));
    w.pre_weight       = 8'(pick_value(8));
    w.place_delay      = 16'(pick_value(16));
    w.source_tokens    = 16'(pick_value(16));
    w.source_waited    = 24'(pick_value(24));
    w.cost_so_far      = pick_value(32);
    return w;
  endfunction

  // Work out the result words of one firing from the predicted tables
  function automatic void predict_firing(input logic [5:0] t, input logic [31:0] cost_in);
    int unsigned act, base, need, step, nw;
    int m;
    longint unsigned cost;
    place_result_t r;
    act  = (active_places > tpt_pkg::MAX_PLACES) ? tpt_pkg::MAX_PLACES : active_places;
    base = int'(t) * tpt_pkg::MAX_PLACES;
    step = 0;
    // first pass: largest unmet holding time over the input arcs
    for (int i = 0; i < act; i++) begin
      need = 32'(hold_time[i]) * 32'(arc_weight[base + i]);
      if (need > src_waited[i] && need - src_waited[i] > step)
        step = need - src_waited[i];
    end
    cost = 64'(cost_in) + 64'(step);
    if (cost > 64'hFFFF_FFFF)
      cost = 64'hFFFF_FFFF;
    // second pass: one word per active place
    for (int i = 0; i < act; i++) begin
      m = int'(src_tokens[i]) + int'(incidence[base + i]);
      r.neg = 1'b0;
      if (m < 0) begin
        m = 0;
        r.neg = 1'b1;
      end
      if (m > 65535) begin
        m = 65535;
        r.neg = 1'b1;
      end
      if (hold_time[i] == 16'd0 || m == 0 || src_tokens[i] == 16'd0) begin
        nw = 0;
      end else begin
        nw = 32'(src_waited[i]) + step;
        if (nw > 32'hFF_FFFF)
          nw = 32'hFF_FFFF;
      end
      r.place  = 6'(i);
      r.tokens = 16'(m);
      r.waited = 24'(nw);
      r.delay  = 24'(step);
      r.cost   = 32'(cost);
      r.tnum   = 7'(t) + 7'd1;
      r.last   = (i == act - 1);
      expected_places.push_back(r);
    end
  endfunction

  // Update the predicted net with one accepted word
  function automatic void apply_net_word(input net_word_t w);
    int unsigned idx;
    idx = int'(w.transition_index) * tpt_pkg::MAX_PLACES + int'(w.place_index);
    case (w.cmd)
      tpt_pkg::CMD_ARC: begin
        incidence[idx]  = w.token_change;
        arc_weight[idx] = w.pre_weight;
      end
      tpt_pkg::CMD_PLACE: begin
        hold_time[w.place_index]  = w.place_delay;
        src_tokens[w.place_index] = w.source_tokens;
        src_waited[w.place_index] = w.source_waited;
      end
      tpt_pkg::CMD_FIRE: predict_firing(w.transition_index, w.cost_so_far);
      default: ;
    endcase
  endfunction

  // Drive one word and hold it until the block takes it; valid stays high
  task automatic send_word(input net_word_t w);
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    item_valid       <= 1'b1;
    cmd              <= w.cmd;
    place_index      <= w.place_index;
    transition_index <= w.transition_index;
    token_change     <= w.token_change;
    pre_weight       <= w.pre_weight;
    place_delay      <= w.place_delay;
    source_tokens    <= w.source_tokens;
    source_waited    <= w.source_waited;
    cost_so_far      <= w.cost_so_far;
    do @(posedge clk); while (item_stall !== 1'b0);
    apply_net_word(w);
    if (w.cmd != CMD_UNUSED)
      words_sent++;
  endtask

  // Hold the input until every expected word is out; optionally let the
  // block finish any firing that gives no words
  task automatic wait_results_done(input bit settle);
    item_valid <= 1'b0;
    do @(posedge clk); while (expected_places.size() != 0);
    if (settle) begin
      repeat (SETTLE_CYCLES) @(posedge clk);
      while (item_stall !== 1'b0) @(posedge clk);
    end
  endtask

  task automatic set_place_count(input logic [6:0] value);
    wait_results_done(1'b1);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en  <= 1'b0;
    active_places = value;
  endtask

  function automatic net_word_t fire_word(input logic [5:0] t, input logic [31:0] c);
    net_word_t w;
    w = random_word();
    w.cmd              = tpt_pkg::CMD_FIRE;
    w.transition_index = t;
    w.cost_so_far      = c;
    return w;
  endfunction

  // Fire from the cleared tables: every word is zero but for numbering and cost
  task automatic test_reset_state();
    wait_results_done(1'b1);
    send_word(fire_word(6'd0, 32'd0));
    send_word(fire_word(6'd63, 32'hFFFF_FFFF));
  endtask

  // Place count at zero, above the table size, and at one
  task automatic test_place_count();
    set_place_count(7'd0);
    send_word(fire_word(6'd0, 32'd7));
    set_place_count(7'd127);
    send_word(fire_word(6'd1, 32'd0));
    set_place_count(7'd1);
    send_word(fire_word(6'd2, 32'd5));
  endtask

  // Clamping, saturation and the wait rules on a four-place net
  task automatic test_extremes();
    net_word_t w;
    set_place_count(7'd4);
    w = random_word();
    w.cmd = tpt_pkg::CMD_PLACE;
    w.place_index = 6'd0; w.place_delay = 16'hFFFF; w.source_tokens = 16'd0;
    w.source_waited = 24'd0;
    send_word(w);
    w.place_index = 6'd1; w.place_delay = 16'd0; w.source_tokens = 16'hFFFF;
    w.source_waited = 24'h12_3456;
    send_word(w);
    w.place_index = 6'd2; w.place_delay = 16'd1; w.source_tokens = 16'hFFFF;
    w.source_waited = 24'hFF_FFFF;
    send_word(w);
    w.place_index = 6'd3; w.place_delay = 16'hFFFF; w.source_tokens = 16'd1;
    w.source_waited = 24'hFF_FFFF;
    send_word(w);
    w = random_word();
    w.cmd = tpt_pkg::CMD_ARC;
    w.transition_index = 6'd5;
    w.place_index = 6'd0; w.token_change = 8'h80; w.pre_weight = 8'hFF;
    send_word(w);
    w.place_index = 6'd1; w.token_change = 8'h7F; w.pre_weight = 8'h00;
    send_word(w);
    w.place_index = 6'd2; w.token_change = 8'hFF; w.pre_weight = 8'h01;
    send_word(w);
    w.place_index = 6'd3; w.token_change = 8'hFF; w.pre_weight = 8'hFF;
    send_word(w);
    // drop a word with the unused command and every field high
    w = '1;
    w.cmd = CMD_UNUSED;
    send_word(w);
    w.cmd = tpt_pkg::CMD_ARC;
    w.token_change = 8'h80;
    send_word(w);
    w.cmd = tpt_pkg::CMD_PLACE;
    send_word(w);
    send_word(fire_word(6'd5, 32'hFFFF_FFFF));
    send_word(fire_word(6'd5, 32'd0));
    set_place_count(7'd64);
    send_word(fire_word(6'd63, 32'd0));
  endtask

  // One random step: mostly load-then-fire sequences, some lone words
  task automatic random_step();
    net_word_t w;
    int unsigned act, sel;
    logic [5:0] t;
    act = (active_places > tpt_pkg::MAX_PLACES) ? tpt_pkg::MAX_PLACES : active_places;
    if (act == 0)
      act = 1;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      t = 6'($urandom);
      repeat ($urandom_range(1, 4)) begin
        w = random_word();
        w.cmd = tpt_pkg::CMD_PLACE;
        w.place_index = 6'($urandom_range(0, act - 1));
        send_word(w);
        w = random_word();
        w.cmd = tpt_pkg::CMD_ARC;
        w.place_index = 6'($urandom_range(0, act - 1));
        w.transition_index = t;
        send_word(w);
      end
      send_word(fire_word(t, pick_value(32)));
    end else if (sel < 68) begin
      w = random_word();
      w.cmd = tpt_pkg::CMD_ARC;
      send_word(w);
    end else if (sel < 78) begin
      w = random_word();
      w.cmd = tpt_pkg::CMD_PLACE;
      send_word(w);
    end else if (sel < 93) begin
      send_word(fire_word(6'($urandom), pick_value(32)));
    end else if (sel < 96) begin
      wait_results_done(1'b0);
    end else begin
      w = random_word();
      w.cmd = CMD_UNUSED;
      send_word(w);
    end
  endtask

  task automatic run_phase(input logic [6:0] places, input int words, input bit idle);
    int target;
    set_place_count(places);
    tx_idle_on = idle;
    rx_idle_on = idle;
    target = words_sent + words;
    while (words_sent < target)
      random_step();
  endtask

  // Mostly small nets, one full-size phase, second and last phases without idling
  task automatic test_random_nets();
    run_phase(7'd6,  60, 1'b1);
    run_phase(7'd2,  50, 1'b0);
    run_phase(7'd12, 60, 1'b1);
    run_phase(7'd64, 30, 1'b1);
    run_phase(7'd1,  40, 1'b1);
    run_phase(7'd24, 60, 1'b1);
    run_phase(7'd4,  50, 1'b0);
  endtask

  // Stall the result channel in random bursts
  initial begin
    forever begin
      @(posedge clk);
      if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  function automatic bit field_ok(input string name, input logic [31:0] exp_v,
                                  input logic [31:0] act_v);
    if (act_v === exp_v)
      return 1'b1;
    if (mismatch_count < MAX_REPORTS)
      $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, name, exp_v, act_v);
    return 1'b0;
  endfunction

  // Compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    place_result_t exp_r;
    bit good;
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      if (expected_places.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("%0t: result word with none expected, place %0d", $realtime, out_place);
        mismatch_count++;
      end else begin
        exp_r = expected_places.pop_front();
        good = 1'b1;
        good &= field_ok("out_place", exp_r.place, out_place);
        good &= field_ok("new_tokens", exp_r.tokens, new_tokens);
        good &= field_ok("new_waited", exp_r.waited, new_waited);
        good &= field_ok("firing_delay", exp_r.delay, firing_delay);
        good &= field_ok("new_cost", exp_r.cost, new_cost);
        good &= field_ok("transition_number", exp_r.tnum, transition_number);
        good &= field_ok("went_negative", exp_r.neg, went_negative);
        good &= field_ok("last", exp_r.last, last);
        if (!good)
          mismatch_count++;
      end
    end
  end

  // End the run when no word moves on either channel for too long
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if ((item_valid === 1'b1 && item_stall === 1'b0) ||
          (result_valid === 1'b1 && result_stall === 1'b0))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_place_count();
    test_extremes();
    test_random_nets();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    wait_results_done(1'b1);
    if (mismatch_count == 0 && expected_places.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
